// File: hdl/tdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdh_pkg;

    localparam int HANDLE_W    = 6;
    localparam int NUM_HANDLES = 64;
    localparam int TIME_W      = 64;

    localparam logic [2:0] K_INSERT  = 3'd0;
    localparam logic [2:0] K_REMOVE  = 3'd1;
    localparam logic [2:0] K_UPDATE  = 3'd2;
    localparam logic [2:0] K_POP     = 3'd3;
    localparam logic [2:0] K_TIMEOUT = 3'd4;
    localparam logic [2:0] K_CLEAR   = 3'd5;
    localparam logic [2:0] K_READ    = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    // one heap slot
    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    localparam int ENTRY_W = TIME_W + HANDLE_W;

endpackage

`default_nettype wire

// File: hdl/tdh_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/timer_deadline_min_heap.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                                        handshake
// request   in         i_kind i_job_id i_deadline i_now             start / busy
// result    out        o_status o_fired o_fired_id o_time_value     o_result_valid pulse
//
// one request at a time; clear, ignored or refused requests: S_LOOK, S_DONE; timeout,
// read, pop with nothing due: S_LOOK, S_GET, S_DONE; insert: S_LOOK, then S_RISE and
// S_RISE_CMP per level climbed, then S_RISE, plus S_RISE_CMP below the root;
// sink: S_SINK, S_SINK_L, S_SINK_R per level; worst is an update sinking from the root
// of a full heap; the single read port of the heap memory allows one access per step
// reset clears the entry count and the handle valid flags at once; no sweep
// busy stays high through the strobe cycle and drops in the cycle after it
// the receiver cannot stall; each result is shown for exactly one cycle

module timer_deadline_min_heap #(
    parameter int MAX_JOBS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    i_kind,
    input  wire logic [tdh_pkg::HANDLE_W-1:0]  i_job_id,
    input  wire logic [tdh_pkg::TIME_W-1:0]    i_deadline,
    input  wire logic [tdh_pkg::TIME_W-1:0]    i_now,
    output logic                               o_result_valid,
    output logic [2:0]                         o_status,
    output logic                               o_fired,
    output logic [tdh_pkg::HANDLE_W-1:0]       o_fired_id,
    output logic [tdh_pkg::TIME_W-1:0]         o_time_value
);

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int XW     = SLOT_W + 2;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_LOOK     = 10'b0000000010,
        S_GET      = 10'b0000000100,
        S_LAST     = 10'b0000001000,
        S_RISE     = 10'b0000010000,
        S_RISE_CMP = 10'b0000100000,
        S_SINK     = 10'b0001000000,
        S_SINK_L   = 10'b0010000000,
        S_SINK_R   = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [2:0]                        r_kind;
    logic [tdh_pkg::HANDLE_W-1:0]      r_id;
    logic [tdh_pkg::TIME_W-1:0]        r_dl, r_now;

    // control state
    logic [CNT_W-1:0]                  r_count, n_count;
    logic [tdh_pkg::NUM_HANDLES-1:0]   r_valid, n_valid;

    // working registers
    logic [SLOT_W-1:0]                 r_slot, n_slot;
    logic [SLOT_W-1:0]                 r_idx, n_idx;
    tdh_pkg::t_entry                   r_cur, n_cur;
    tdh_pkg::t_entry                   r_left, n_left;
    logic [tdh_pkg::TIME_W-1:0]        r_old, n_old;
    logic                              r_fired, n_fired;
    logic [tdh_pkg::HANDLE_W-1:0]      r_fid, n_fid;

    // result registers
    logic                              r_rv, n_rv;
    logic [2:0]                        r_st, n_st;
    logic                              r_of, n_of;
    logic [tdh_pkg::HANDLE_W-1:0]      r_ofid, n_ofid;
    logic [tdh_pkg::TIME_W-1:0]        r_tv, n_tv;

    // memory ports
    logic                              heap_we;
    logic [SLOT_W-1:0]                 heap_waddr, heap_raddr;
    tdh_pkg::t_entry                   heap_wdata, heap_rdata;
    logic                              slot_we;
    logic [tdh_pkg::HANDLE_W-1:0]      slot_waddr;
    logic [SLOT_W-1:0]                 slot_wdata, slot_rdata;

    tdh_ram #(.WIDTH(tdh_pkg::ENTRY_W), .DEPTH(MAX_JOBS)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    // handle -> heap slot map, validity kept in r_valid
    tdh_ram #(.WIDTH(SLOT_W), .DEPTH(tdh_pkg::NUM_HANDLES)) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (i_job_id),
        .o_rdata (slot_rdata)
    );

    logic              accept;
    logic              present;
    logic [CNT_W-1:0]  cnt_dec;
    logic [SLOT_W:0]   l_idx, r_idx_c;
    logic [SLOT_W-1:0] p_idx;
    tdh_pkg::t_entry   cand;
    logic [SLOT_W-1:0] cand_idx;

    assign accept  = start && !busy;
    assign present = r_valid[r_id];
    assign cnt_dec = r_count - CNT_W'(1);
    assign l_idx   = {r_idx, 1'b1};
    assign r_idx_c = l_idx + (SLOT_W + 1)'(1);
    assign p_idx   = (r_idx - SLOT_W'(1)) >> 1;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_valid    = r_valid;
        n_slot     = r_slot;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_left     = r_left;
        n_old      = r_old;
        n_fired    = r_fired;
        n_fid      = r_fid;
        n_rv       = 1'b0;
        n_st       = r_st;
        n_of       = r_of;
        n_ofid     = r_ofid;
        n_tv       = r_tv;
        heap_we    = 1'b0;
        heap_waddr = r_idx;
        heap_wdata = r_cur;
        heap_raddr = r_slot;
        slot_we    = 1'b0;
        slot_waddr = r_cur.handle;
        slot_wdata = r_idx;
        cand       = r_left;
        cand_idx   = l_idx[SLOT_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_fired = 1'b0;
                    n_fid   = '0;
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                n_slot     = slot_rdata;
                heap_raddr = slot_rdata;
                n_state    = S_DONE;
                n_st       = tdh_pkg::ST_OK;
                n_tv       = '0;
                case (r_kind)
                    tdh_pkg::K_INSERT: begin
                        if (present) begin
                            n_st = tdh_pkg::ST_PRESENT;
                        end else if (r_count == CNT_W'(MAX_JOBS)) begin
                            n_st = tdh_pkg::ST_FULL;
                        end else begin
                            n_idx   = SLOT_W'(r_count);
                            n_count = r_count + CNT_W'(1);
                            n_cur   = '{deadline: r_dl, handle: r_id};
                            n_state = S_RISE;
                        end
                    end
                    tdh_pkg::K_REMOVE, tdh_pkg::K_UPDATE, tdh_pkg::K_READ: begin
                        if (!present) begin
                            n_st = tdh_pkg::ST_ABSENT;
                        end else begin
                            n_state = S_GET;
                        end
                    end
                    tdh_pkg::K_POP, tdh_pkg::K_TIMEOUT: begin
                        n_slot     = '0;
                        heap_raddr = '0;
                        if (r_count == '0) begin
                            n_st = tdh_pkg::ST_NONE;
                        end else begin
                            n_state = S_GET;
                        end
                    end
                    tdh_pkg::K_CLEAR: begin
                        n_valid = '0;
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end

            S_GET: begin
                n_old      = heap_rdata.deadline;
                heap_raddr = SLOT_W'(cnt_dec);
                n_state    = S_DONE;
                case (r_kind)
                    tdh_pkg::K_READ: begin
                        n_tv = heap_rdata.deadline;
                    end
                    tdh_pkg::K_TIMEOUT: begin
                        n_tv = (heap_rdata.deadline > r_now) ?
                               heap_rdata.deadline - r_now : '0;
                    end
                    tdh_pkg::K_UPDATE: begin
                        n_cur = '{deadline: r_dl, handle: r_id};
                        n_idx = r_slot;
                        n_state = (r_dl < heap_rdata.deadline) ? S_RISE : S_SINK;
                    end
                    default: begin
                        // remove, or pop of an expired head
                        if (r_kind == tdh_pkg::K_POP && heap_rdata.deadline > r_now) begin
                            n_st = tdh_pkg::ST_NONE;
                        end else begin
                            if (r_kind == tdh_pkg::K_POP) begin
                                n_fired = 1'b1;
                                n_fid   = heap_rdata.handle;
                            end
                            n_valid[heap_rdata.handle] = 1'b0;
                            n_count = cnt_dec;
                            if (cnt_dec != '0 && CNT_W'(r_slot) != cnt_dec) begin
                                n_state = S_LAST;
                            end
                        end
                    end
                endcase
            end

            S_LAST: begin
                // last entry moves into the freed slot
                n_cur   = heap_rdata;
                n_idx   = r_slot;
                n_state = (heap_rdata.deadline < r_old) ? S_RISE : S_SINK;
            end

            S_RISE: begin
                heap_raddr = p_idx;
                if (r_idx == '0) begin
                    heap_we = 1'b1;
                    slot_we = 1'b1;
                    n_valid[r_cur.handle] = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RISE_CMP;
                end
            end

            S_RISE_CMP: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (r_cur.deadline < heap_rdata.deadline) begin
                    // parent moves down one level
                    heap_wdata = heap_rdata;
                    slot_waddr = heap_rdata.handle;
                    n_idx      = p_idx;
                    n_state    = S_RISE;
                end else begin
                    n_valid[r_cur.handle] = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_SINK: begin
                heap_raddr = l_idx[SLOT_W-1:0];
                if (XW'(r_idx) >= XW'(r_count >> 1)) begin
                    heap_we = 1'b1;
                    slot_we = 1'b1;
                    n_valid[r_cur.handle] = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SINK_L;
                end
            end

            S_SINK_L, S_SINK_R: begin
                heap_raddr = r_idx_c[SLOT_W-1:0];
                if (r_state == S_SINK_L) begin
                    n_left = heap_rdata;
                    cand   = heap_rdata;
                end else if (heap_rdata.deadline < r_left.deadline) begin
                    cand     = heap_rdata;
                    cand_idx = r_idx_c[SLOT_W-1:0];
                end
                if (r_state == S_SINK_L && XW'(r_idx_c) < XW'(r_count)) begin
                    n_state = S_SINK_R;
                end else begin
                    heap_we = 1'b1;
                    slot_we = 1'b1;
                    if (r_cur.deadline < cand.deadline) begin
                        n_valid[r_cur.handle] = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // smaller child moves up one level
                        heap_wdata = cand;
                        slot_waddr = cand.handle;
                        n_idx      = cand_idx;
                        n_state    = S_SINK;
                    end
                end
            end

            S_DONE: begin
                n_rv    = 1'b1;
                n_of    = r_fired;
                n_ofid  = r_fid;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_rv    <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_id   <= i_job_id;
            r_dl   <= i_deadline;
            r_now  <= i_now;
        end
        r_slot  <= n_slot;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_left  <= n_left;
        r_old   <= n_old;
        r_fired <= n_fired;
        r_fid   <= n_fid;
        r_st    <= n_st;
        r_of    <= n_of;
        r_ofid  <= n_ofid;
        r_tv    <= n_tv;
    end

    assign busy           = (r_state != S_IDLE) || r_rv;
    assign o_result_valid = r_rv;
    assign o_status       = r_st;
    assign o_fired        = r_of;
    assign o_fired_id     = r_ofid;
    assign o_time_value   = r_tv;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_fired) |-> (o_status == tdh_pkg::ST_OK))
        else $error("fired job with non-ok status");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
